FILE: hdl/rsfsc_pkg.sv
// Package for the frame sync and CRC check block: shared constants, types,
// controller/datapath command and status structs, CRC-16 byte update.
// No dependencies.
package rsfsc_pkg;

    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_MAX_DATA_LEN = 32;
    localparam int DATA_START       = 8;   // header bytes before the data section
    localparam int HDR_IW           = 3;   // index width over the header bytes
    localparam int LSW              = 9;   // width of sums built on the length byte

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int TDATA_W = 96;
    localparam int TUSER_W = 3;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_ERR  = 2'd1,
        ST_OVR  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR,
        S_LCHK,
        S_CRC,
        S_CWAIT,
        S_CMP,
        S_ERD,
        S_EOUT,
        S_ERR,
        S_OVR
    } t_state;

    typedef struct packed {
        logic    wr;          // store the accepted byte, restart the scan
        logic    rd_scan;     // header/CRC read at the scan index
        logic    rd_emit;     // data byte read for a result
        logic    idx_data;    // move the read index to the data section
        logic    drop_one;
        logic    drop_frame;
        logic    out_load;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        logic full;           // window full, next byte overruns
        logic near;           // the next byte completes a minimal frame
        logic idx_hdr_end;    // last header byte being read
        logic idx_crc_end;    // last checksum byte being read
        logic len_bad;
        logic short_frame;    // frame announced but not all present
        logic crc_ok;
        logic emit_last;
        logic out_free;
    } t_sts;

    // Reflected CRC-16 update with one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/rsfsc_ctrl.sv
// Sequencer for the frame sync and CRC check block: steps the byte write,
// header read, length check, CRC walk and result emission.
// Depends on rsfsc_pkg.
module rsfsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rsfsc_pkg::t_sts   i_sts,
    output rsfsc_pkg::t_cmd   o_cmd
);

    rsfsc_pkg::t_state r_state;
    rsfsc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsfsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsfsc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.full)
                        n_state = rsfsc_pkg::S_OVR;
                    else if (i_sts.near)
                        n_state = rsfsc_pkg::S_HDR;
                end
            end
            rsfsc_pkg::S_HDR: begin
                if (i_sts.idx_hdr_end)
                    n_state = rsfsc_pkg::S_LCHK;
            end
            rsfsc_pkg::S_LCHK: begin
                if (i_sts.len_bad)
                    n_state = rsfsc_pkg::S_ERR;
                else if (i_sts.short_frame)
                    n_state = rsfsc_pkg::S_IDLE;
                else
                    n_state = rsfsc_pkg::S_CRC;
            end
            rsfsc_pkg::S_CRC: begin
                if (i_sts.idx_crc_end)
                    n_state = rsfsc_pkg::S_CWAIT;
            end
            rsfsc_pkg::S_CWAIT: n_state = rsfsc_pkg::S_CMP;
            rsfsc_pkg::S_CMP: begin
                n_state = i_sts.crc_ok ? rsfsc_pkg::S_ERD : rsfsc_pkg::S_ERR;
            end
            rsfsc_pkg::S_ERD: n_state = rsfsc_pkg::S_EOUT;
            rsfsc_pkg::S_EOUT: begin
                if (i_sts.out_free)
                    n_state = i_sts.emit_last ? rsfsc_pkg::S_IDLE : rsfsc_pkg::S_ERD;
            end
            rsfsc_pkg::S_ERR, rsfsc_pkg::S_OVR: begin
                if (i_sts.out_free)
                    n_state = rsfsc_pkg::S_IDLE;
            end
            default: n_state = rsfsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = rsfsc_pkg::ST_GOOD;
        o_in_ready       = 1'b0;
        case (r_state)
            rsfsc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.wr   = i_in_valid & ~i_sts.full;
            end
            rsfsc_pkg::S_HDR: o_cmd.rd_scan = 1'b1;
            rsfsc_pkg::S_LCHK: o_cmd.drop_one = i_sts.len_bad;
            rsfsc_pkg::S_CRC: o_cmd.rd_scan = 1'b1;
            rsfsc_pkg::S_CMP: begin
                o_cmd.idx_data = i_sts.crc_ok;
                o_cmd.drop_one = ~i_sts.crc_ok;
            end
            rsfsc_pkg::S_ERD: o_cmd.rd_emit = 1'b1;
            rsfsc_pkg::S_EOUT: begin
                o_cmd.out_load   = i_sts.out_free;
                o_cmd.drop_frame = i_sts.out_free & i_sts.emit_last;
            end
            rsfsc_pkg::S_ERR: begin
                o_cmd.out_load   = i_sts.out_free;
                o_cmd.out_status = rsfsc_pkg::ST_ERR;
            end
            rsfsc_pkg::S_OVR: begin
                o_cmd.out_load   = i_sts.out_free;
                o_cmd.out_status = rsfsc_pkg::ST_OVR;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hdl/rsfsc_dp.sv
// Datapath for the frame sync and CRC check block: circular byte window in
// a single-port memory, header capture, CRC-16, drop logic, result register.
// Depends on rsfsc_pkg.
module rsfsc_dp #(
    parameter int WINDOW_DEPTH = rsfsc_pkg::DEF_WINDOW_DEPTH,
    parameter int MAX_DATA_LEN = rsfsc_pkg::DEF_MAX_DATA_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [7:0]                     i_rx_byte,
    input  rsfsc_pkg::t_cmd                i_cmd,
    output rsfsc_pkg::t_sts                o_sts,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rsfsc_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [rsfsc_pkg::TUSER_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int IW = $clog2(rsfsc_pkg::DATA_START + MAX_DATA_LEN + 2);
    localparam int CW = ((FW > rsfsc_pkg::LSW) ? FW : rsfsc_pkg::LSW) + 1;

    logic [7:0]    r_mem [WINDOW_DEPTH];
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] r_rd_pos;
    logic          r_rd_vld;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_hdr [rsfsc_pkg::DATA_START];
    logic [15:0]   r_crc;
    logic [15:0]   r_carried;

    logic          r_out_vld;
    logic [1:0]    r_out_status;
    logic          r_out_dvalid;
    logic [15:0]   r_out_dest;
    logic [15:0]   r_out_src;
    logic [5:0]    r_out_len;
    logic [15:0]   r_out_res;
    logic [7:0]    r_out_func;
    logic [4:0]    r_out_idx;
    logic [7:0]    r_out_byte;
    logic [15:0]   r_out_crc;
    logic          r_out_last;

    logic [CW-1:0] len_c;
    logic [CW-1:0] frame_len;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] idx_c;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_any;
    logic          len_zero;
    logic          out_free;

    function automatic logic [AW-1:0] f_wrap(input logic [CW-1:0] s);
        logic [CW-1:0] d;
        d = s - CW'(WINDOW_DEPTH);
        return (s >= CW'(WINDOW_DEPTH)) ? d[AW-1:0] : s[AW-1:0];
    endfunction

    assign len_c     = CW'(r_hdr[4]);
    assign frame_len = len_c + CW'(rsfsc_pkg::DATA_START + 2);
    assign pos_c     = CW'(r_rd_pos);
    assign idx_c     = CW'(r_rd_idx);
    assign wr_addr   = f_wrap(CW'(r_head) + CW'(r_fill));
    assign rd_addr   = f_wrap(CW'(r_head) + idx_c);
    assign rd_any    = i_cmd.rd_scan | i_cmd.rd_emit;
    assign len_zero  = (r_hdr[4] == 8'd0);
    assign out_free  = ~r_out_vld | m_axis_tready;

    always_comb begin
        o_sts.full        = (r_fill == FW'(WINDOW_DEPTH));
        o_sts.near        = (r_fill >= FW'(rsfsc_pkg::DATA_START + 1));
        o_sts.idx_hdr_end = (idx_c == CW'(rsfsc_pkg::DATA_START - 1));
        o_sts.idx_crc_end = (idx_c == len_c + CW'(rsfsc_pkg::DATA_START + 1));
        o_sts.len_bad     = (len_c > CW'(MAX_DATA_LEN)) || (frame_len > CW'(WINDOW_DEPTH));
        o_sts.short_frame = (CW'(r_fill) < frame_len);
        o_sts.crc_ok      = (r_carried == r_crc);
        o_sts.emit_last   = len_zero ||
                            (pos_c == len_c + CW'(rsfsc_pkg::DATA_START - 1));
        o_sts.out_free    = out_free;
    end

    // window store and registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr)
            r_mem[wr_addr] <= i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (rd_any) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_pos  <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_scan;
            if (i_cmd.wr)
                r_rd_idx <= '0;
            else if (i_cmd.idx_data)
                r_rd_idx <= IW'(rsfsc_pkg::DATA_START);
            else if (rd_any)
                r_rd_idx <= r_rd_idx + IW'(1);

            if (i_cmd.wr) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_cmd.drop_one) begin
                r_head <= f_wrap(CW'(r_head) + CW'(1));
                r_fill <= r_fill - FW'(1);
            end else if (i_cmd.drop_frame) begin
                r_head <= f_wrap(CW'(r_head) + frame_len);
                r_fill <= r_fill - frame_len[FW-1:0];
            end
        end
    end

    // header capture, CRC walk and carried checksum
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_crc <= rsfsc_pkg::CRC_INIT;
        end else if (r_rd_vld) begin
            if (pos_c < CW'(rsfsc_pkg::DATA_START))
                r_hdr[r_rd_pos[rsfsc_pkg::HDR_IW-1:0]] <= r_rd_data;
            if (pos_c < len_c + CW'(rsfsc_pkg::DATA_START))
                r_crc <= rsfsc_pkg::crc16_byte(r_crc, r_rd_data);
            if (pos_c == len_c + CW'(rsfsc_pkg::DATA_START))
                r_carried[7:0] <= r_rd_data;
            if (pos_c == len_c + CW'(rsfsc_pkg::DATA_START + 1))
                r_carried[15:8] <= r_rd_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            if (i_cmd.out_status == rsfsc_pkg::ST_GOOD) begin
                r_out_dest   <= {r_hdr[1], r_hdr[0]};
                r_out_src    <= {r_hdr[3], r_hdr[2]};
                r_out_len    <= r_hdr[4][5:0];
                r_out_res    <= {r_hdr[6], r_hdr[5]};
                r_out_func   <= r_hdr[7];
                r_out_dvalid <= ~len_zero;
                r_out_idx    <= len_zero ? 5'd0
                                         : 5'(r_rd_pos - IW'(rsfsc_pkg::DATA_START));
                r_out_byte   <= len_zero ? 8'd0 : r_rd_data;
                r_out_crc    <= r_carried;
                r_out_last   <= o_sts.emit_last;
            end else begin
                r_out_dest   <= '0;
                r_out_src    <= '0;
                r_out_len    <= '0;
                r_out_res    <= '0;
                r_out_func   <= '0;
                r_out_dvalid <= 1'b0;
                r_out_idx    <= '0;
                r_out_byte   <= '0;
                r_out_crc    <= '0;
                r_out_last   <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_dvalid, r_out_status};
    assign m_axis_tdata  = {5'd0, r_out_crc, r_out_byte, r_out_idx, r_out_func,
                            r_out_res, r_out_len, r_out_src, r_out_dest};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> (r_fill < FW'(WINDOW_DEPTH)))
        else $error("byte stored into a full window");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten while stalled");

    a_drop_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop_frame |-> (CW'(r_fill) >= frame_len))
        else $error("frame dropped with fewer bytes held");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status != rsfsc_pkg::ST_GOOD) |-> r_out_last)
        else $error("error request without last");
`endif

endmodule

FILE: hdl/rs485_frame_sync_crc_check.sv
// Top level of the bus frame sync and CRC-16 check block.
// Depends on rsfsc_pkg, rsfsc_ctrl, rsfsc_dp.
//
//  channel  | dir | tdata                                         | tuser
//  s_axis   | in  | [7:0] rx_byte                                 | -
//  m_axis   | out | dest, src, len, reserved, func, idx, byte, crc | status, data_valid
//
// A byte offered to a full window gives an overrun request, else it is written; once a
// minimal frame is held, the 8 header bytes are read and the length checked: a short
// frame returns to idle, a bad length gives an error request; a complete frame has its
// CRC walked, then gives an error request or one result per data byte (one if empty).
// i_rst_n is synchronous; it empties the window, window memory itself is not cleared.
// s_axis_tready is high only between requests; a stalled result holds the sequencer.
module rs485_frame_sync_crc_check #(
    parameter int WINDOW_DEPTH = rsfsc_pkg::DEF_WINDOW_DEPTH,
    parameter int MAX_DATA_LEN = rsfsc_pkg::DEF_MAX_DATA_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] dest_addr, [31:16] source, [37:32] data_length,
    // [53:38] reserved_word, [61:54] function_code, [66:62] data_index,
    // [74:67] data_byte, [90:75] frame_crc, [95:91] zero
    output logic [rsfsc_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status, [2] data_valid
    output logic [rsfsc_pkg::TUSER_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast
);

    rsfsc_pkg::t_cmd cmd;
    rsfsc_pkg::t_sts sts;

    rsfsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rsfsc_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_DATA_LEN (MAX_DATA_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: dv/rsfsc_frame_checker.sv
// Checker for the frame sync and CRC-16 check block: follows the byte window,
// predicts the result items of each accepted rx byte and compares them in order.
// Depends on rsfsc_pkg for the widths, the window defaults and the status codes.
module rsfsc_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,    // [7:0] rx_byte
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] dest, [31:16] src, [37:32] len, [53:38] reserved, [61:54] func,
    // [66:62] data index, [74:67] data byte, [90:75] frame crc
    input  logic [rsfsc_pkg::TDATA_W-1:0] i_m_axis_tdata,
    input  logic [rsfsc_pkg::TUSER_W-1:0] i_m_axis_tuser,    // [1:0] status, [2] data_valid
    input  logic                          i_m_axis_tlast,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int WIN_DEPTH   = rsfsc_pkg::DEF_WINDOW_DEPTH;
    localparam int MAX_LEN     = rsfsc_pkg::DEF_MAX_DATA_LEN;
    localparam int HDR_LEN     = rsfsc_pkg::DATA_START;
    localparam int MIN_FRAME   = HDR_LEN + 2;

    typedef struct packed {
        rsfsc_pkg::t_status status;
        logic [15:0]        dest;
        logic [15:0]        src;
        logic [5:0]         len;
        logic [15:0]        rsv;
        logic [7:0]         func;
        logic               dvalid;
        logic [4:0]         idx;
        logic [7:0]         dbyte;
        logic [15:0]        crc;
        logic               last;
    } t_frame_result;

    logic [7:0]    rx_window [WIN_DEPTH];
    int unsigned   win_fill  = 0;
    int unsigned   win_head  = 0;
    t_frame_result due_results [$];
    int            fails     = 0;
    int            due_count = 0;

    assign o_fail_count = fails;
    assign o_pending    = due_count;

    function automatic logic [7:0] win_byte(input int unsigned pos);
        return rx_window[(win_head + pos) % WIN_DEPTH];
    endfunction

    // Modbus CRC over the first count window bytes, bit at a time
    function automatic logic [15:0] window_crc(input int unsigned count);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int unsigned i = 0; i < count; i++) begin
            c ^= {8'h00, win_byte(i)};
            for (int b = 0; b < 8; b++) begin
                if (c[0]) begin
                    c = (c >> 1) ^ 16'hA001;
                end else begin
                    c = c >> 1;
                end
            end
        end
        return c;
    endfunction

    function automatic string show(input t_frame_result r);
        return {$sformatf("st=%0d dst=%h src=%h len=%0d rsv=%h fn=%h ",
                          r.status, r.dest, r.src, r.len, r.rsv, r.func),
                $sformatf("dv=%b ix=%0d db=%h crc=%h last=%b",
                          r.dvalid, r.idx, r.dbyte, r.crc, r.last)};
    endfunction

    task automatic drop_bytes(input int unsigned n);
        if (n > win_fill) n = win_fill;
        win_head = (win_head + n) % WIN_DEPTH;
        win_fill -= n;
    endtask

    task automatic push_flag(input rsfsc_pkg::t_status st);
        t_frame_result r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        due_results.push_back(r);
    endtask

    task automatic take_rx_byte(input logic [7:0] b);
        int unsigned   len;
        int unsigned   flen;
        int unsigned   n;
        logic [15:0]   carried;
        t_frame_result r;
        if (win_fill >= WIN_DEPTH) begin
            push_flag(rsfsc_pkg::ST_OVR);
            return;
        end
        rx_window[(win_head + win_fill) % WIN_DEPTH] = b;
        win_fill++;
        if (win_fill < MIN_FRAME) return;

        len  = win_byte(4);
        flen = HDR_LEN + len + 2;
        if (len > MAX_LEN || flen > WIN_DEPTH) begin
            drop_bytes(1);
            push_flag(rsfsc_pkg::ST_ERR);
            return;
        end
        if (win_fill < flen) return;

        carried = {win_byte(HDR_LEN + len + 1), win_byte(HDR_LEN + len)};
        if (carried != window_crc(HDR_LEN + len)) begin
            drop_bytes(1);
            push_flag(rsfsc_pkg::ST_ERR);
            return;
        end

        // empty data section still gives one result, with no data byte
        n = (len == 0) ? 1 : len;
        for (int unsigned k = 0; k < n; k++) begin
            r        = '0;
            r.status = rsfsc_pkg::ST_GOOD;
            r.dest   = {win_byte(1), win_byte(0)};
            r.src    = {win_byte(3), win_byte(2)};
            r.len    = len[5:0];
            r.rsv    = {win_byte(6), win_byte(5)};
            r.func   = win_byte(7);
            r.dvalid = (len != 0);
            r.idx    = (len != 0) ? k[4:0] : 5'd0;
            r.dbyte  = (len != 0) ? win_byte(HDR_LEN + k) : 8'h00;
            r.crc    = carried;
            r.last   = (k + 1 == n);
            due_results.push_back(r);
        end
        drop_bytes(flen);
    endtask

    // Inputs change just after the rising edge, so the falling edge sees what
    // the next rising edge will take. Results are compared before the new byte
    // is predicted: a result can't come from a request taken at the same edge.
    always @(negedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (!i_rst_n) begin
            win_fill = 0;
            win_head = 0;
            due_results.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got        = '0;
                got.status = rsfsc_pkg::t_status'(i_m_axis_tuser[1:0]);
                got.dvalid = i_m_axis_tuser[2];
                got.dest   = i_m_axis_tdata[15:0];
                got.src    = i_m_axis_tdata[31:16];
                got.len    = i_m_axis_tdata[37:32];
                got.rsv    = i_m_axis_tdata[53:38];
                got.func   = i_m_axis_tdata[61:54];
                got.idx    = i_m_axis_tdata[66:62];
                got.dbyte  = i_m_axis_tdata[74:67];
                got.crc    = i_m_axis_tdata[90:75];
                got.last   = i_m_axis_tlast;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %s",
                             $time, show(got));
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: result differs, expected %s", $time, show(want));
                        $display("%0t:                  actual %s", $time, show(got));
                        fails++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) take_rx_byte(i_s_axis_tdata);
        end
        due_count = due_results.size();
    end

endmodule

FILE: dv/testbench.sv
// Top of the frame sync and CRC-16 check testbench: clock, reset, byte stream
// stimulus, result-side stalls and the verdict.
// Depends on rsfsc_pkg, rs485_frame_sync_crc_check and rsfsc_frame_checker.
module testbench;

    typedef enum {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_LEN
    } t_frame_kind;

    localparam int RX_TARGET     = 350;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT       = 120;
    localparam int TAIL_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int HDR_LEN       = rsfsc_pkg::DATA_START;
    localparam int MAX_LEN       = rsfsc_pkg::DEF_MAX_DATA_LEN;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // header, index, byte, crc; see block ports
    logic [rsfsc_pkg::TDATA_W-1:0] m_axis_tdata;
    logic [rsfsc_pkg::TUSER_W-1:0] m_axis_tuser;            // [1:0] status, [2] data_valid
    logic                          m_axis_tlast;

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int cycles     = 0;
    bit no_idle    = 1'b0;
    bit hold_done  = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rs485_frame_sync_crc_check uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rsfsc_frame_checker frame_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a rising edge; returns at the edge that took the request, or after the idle gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        bytes_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // fill_val below zero gives random data bytes
    task automatic send_frame(input logic [15:0] dest, input logic [15:0] src,
                              input logic [15:0] rsv, input logic [7:0] func,
                              input int len, input int fill_val, input t_frame_kind kind);
        logic [7:0]  hdr [8];
        logic [7:0]  len_byte;
        logic [7:0]  b;
        logic [15:0] crc;
        len_byte = (kind == FR_BAD_LEN) ? 8'($urandom_range(MAX_LEN + 1, 255))
                                        : 8'(len);
        hdr = '{dest[7:0], dest[15:8], src[7:0], src[15:8], len_byte, rsv[7:0], rsv[15:8], func};
        crc = rsfsc_pkg::CRC_INIT;
        for (int i = 0; i < HDR_LEN; i++) begin
            send_byte(hdr[i]);
            crc = rsfsc_pkg::crc16_byte(crc, hdr[i]);
        end
        if (kind == FR_BAD_LEN) begin
            // just enough tail for the length check to fire
            send_byte(8'($urandom));
            send_byte(8'($urandom));
            return;
        end
        for (int k = 0; k < len; k++) begin
            b = (fill_val < 0) ? 8'($urandom) : 8'(fill_val);
            send_byte(b);
            crc = rsfsc_pkg::crc16_byte(crc, b);
        end
        if (kind == FR_BAD_CRC) crc ^= 16'($urandom_range(1, 16'hFFFF));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    // result side; the single long hold lets the window back up into the input
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && bytes_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                stall     = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else begin
                stall = idle_gap();
                if (stall > 0) begin
                    stall--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          r;
        int          len;
        t_frame_kind kind;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty data with all-ones and zero header fields in turn, two bytes of all-ones data with
        // those fields swapped, a length past the maximum, then a full data section.
        // A full window can't happen at this depth: a frame is at most 42 bytes.
        send_frame(16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 0, -1, FR_GOOD);
        send_frame(16'h0000, 16'hFFFF, 16'h0000, 8'h00, 2, 8'hFF, FR_GOOD);
        send_frame(16'h1234, 16'h5678, 16'h0000, 8'd11, 0, -1, FR_BAD_LEN);
        send_frame(16'($urandom), 16'($urandom), 16'($urandom), 8'd12,
                   MAX_LEN, -1, FR_GOOD);

        while (bytes_sent < RX_TARGET) begin
            no_idle = ($urandom_range(0, 4) == 0);
            // line noise between frames now and then
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(0, 4);
            else if (r < 95) len = $urandom_range(5, 16);
            else             len = $urandom_range(17, MAX_LEN);
            r = $urandom_range(0, 19);
            if (r == 0)     kind = FR_BAD_LEN;
            else if (r < 3) kind = FR_BAD_CRC;
            else            kind = FR_GOOD;
            send_frame(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                       len, -1, kind);
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
